@@ design/mre_pkg.sv @@
// ----------------------------------------------------------------------------
// mre_pkg
// Types, widths, operation codes and saturation helper shared by the matrix
// row operation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mre_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 4;
    localparam int DIM_W        = 5;
    localparam int FUNC_W       = 3;
    localparam int RESULT_LIMIT = 16;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 2;

    // Q16.16 product handling widths
    localparam int PROD_W = 2 * DATA_W;
    localparam int QUOT_W = PROD_W - 16;
    localparam int DIFF_W = QUOT_W + 1;

    // Cycles to wait after the last row read so every write-back has landed
    localparam logic [2:0] PIPE_DRAIN = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1
    } cfg_reg_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 3'd0,
        FN_READ  = 3'd1,
        FN_ROW   = 3'd2,
        FN_COL   = 3'd3,
        FN_SWAP  = 3'd4,
        FN_SCALE = 3'd5,
        FN_SUB   = 3'd6
    } func_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        hi = DIFF_W'(64'sd2147483647);
        lo = DIFF_W'(-64'sd2147483648);
        if (v > hi)
            return 32'sh7FFFFFFF;
        else if (v < lo)
            return 32'sh80000000;
        else
            return $signed(v[DATA_W-1:0]);
    endfunction

endpackage

`default_nettype wire

@@ design/mre_store.sv @@
// ----------------------------------------------------------------------------
// mre_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_store
    import mre_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/mre_arith.sv @@
// ----------------------------------------------------------------------------
// mre_arith
// Three-stage write-back path for scale and subtract: multiply, truncate
// the Q16.16 product toward zero, then subtract and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_arith
    import mre_pkg::*;
#(
    parameter int ADDR_W = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_is_sub,
    input  wire logic signed [DATA_W-1:0] in_a,
    input  wire logic signed [DATA_W-1:0] in_b,
    input  wire logic signed [DATA_W-1:0] in_factor,
    input  wire logic        [ADDR_W-1:0] in_addr,
    output logic                          wr_valid,
    output logic             [ADDR_W-1:0] wr_addr,
    output logic signed      [DATA_W-1:0] wr_data
);

    logic signed [DATA_W-1:0] mul_src;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [QUOT_W-1:0] quot_next;
    logic signed [DIFF_W-1:0] diff_next;

    logic                     p_valid_reg;
    logic                     p_sub_reg;
    logic signed [DATA_W-1:0] p_a_reg;
    logic        [ADDR_W-1:0] p_addr_reg;
    logic signed [PROD_W-1:0] p_prod_reg;

    logic                     q_valid_reg;
    logic                     q_sub_reg;
    logic signed [DATA_W-1:0] q_a_reg;
    logic        [ADDR_W-1:0] q_addr_reg;
    logic signed [QUOT_W-1:0] q_quot_reg;

    logic                     w_valid_reg;
    logic        [ADDR_W-1:0] w_addr_reg;
    logic signed [DATA_W-1:0] w_data_reg;

    assign mul_src   = in_is_sub ? in_b : in_a;
    assign prod_next = PROD_W'(mul_src) * PROD_W'(in_factor);

    // bias negative products so the arithmetic shift truncates toward zero
    assign prod_adj  = p_prod_reg + (p_prod_reg[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    assign quot_next = $signed(prod_adj[PROD_W-1:16]);

    assign diff_next = q_sub_reg ? (DIFF_W'(q_a_reg) - DIFF_W'(q_quot_reg))
                                 : DIFF_W'(q_quot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            q_valid_reg <= p_valid_reg;
            w_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_sub_reg  <= in_is_sub;
        p_a_reg    <= in_a;
        p_addr_reg <= in_addr;
        p_prod_reg <= prod_next;

        q_sub_reg  <= p_sub_reg;
        q_a_reg    <= p_a_reg;
        q_addr_reg <= p_addr_reg;
        q_quot_reg <= quot_next;

        w_addr_reg <= q_addr_reg;
        w_data_reg <= sat32(diff_next);
    end

    assign wr_valid = w_valid_reg;
    assign wr_addr  = w_addr_reg;
    assign wr_data  = w_data_reg;

endmodule

`default_nettype wire

@@ design/matrix_row_operation_engine.sv @@
// ----------------------------------------------------------------------------
// matrix_row_operation_engine
// Holds a Q16.16 matrix in one memory and runs element access, row/column
// streaming, row swap, row scale and row subtract on it.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   tdata: rows, column, value, factor
//                                             tuser: operation code
//  m_*       out        m_tvalid / m_tready   tdata: value, position; tlast; tuser
//  cfg_*     in         cfg_valid / cfg_ready index, data (always ready)
//
//  One operation at a time. A read streams its elements one by one: each
//  element is read from memory, then loaded into the output register.
//  Swap, scale and subtract make two memory reads per column through the
//  single read port, then drain the write-back pipeline. A zero factor
//  skips the row pass.
//  Results wait in an output register; m_tready low stalls the sequencer.
//  Reset clears control state only; memory contents are unknown until written.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_row_operation_engine
    import mre_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // [3:0] first_row, [7:4] second_row, [11:8] column_index,
    // [43:12] write_value, [75:44] scale_factor, [79:76] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [2:0] func
    input  wire logic [FUNC_W-1:0]    s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [31:0] read_value, [35:32] position, [39:36] zero
    output logic      [M_TDATA_W-1:0] m_tdata,
    // [0] status
    output logic      [0:0]           m_tuser,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MUL_W  = ADDR_W + IDX_W + 1;
    localparam int ROW_LIM_I = (MAX_ROWS < RESULT_LIMIT) ? MAX_ROWS : RESULT_LIMIT;
    localparam int COL_LIM_I = (MAX_COLS < RESULT_LIMIT) ? MAX_COLS : RESULT_LIMIT;
    localparam logic [DIM_W-1:0] ROW_LIM = DIM_W'(ROW_LIM_I);
    localparam logic [DIM_W-1:0] COL_LIM = DIM_W'(COL_LIM_I);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ROW_ISSUE,
        S_ROW_DRAIN,
        S_RD_ISSUE,
        S_RD_DATA,
        S_RESP
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        logic [MUL_W-1:0] full;
        full = MUL_W'(r) * MUL_W'(MAX_COLS) + MUL_W'(c);
        return full[ADDR_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        if (v == '0)
            return DIM_W'(1);
        else if (v > lim)
            return lim;
        else
            return v;
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0] nr_reg;
    logic [DIM_W-1:0] nc_reg;

    func_t                    func_reg;
    logic [IDX_W-1:0]         ra_reg;
    logic [IDX_W-1:0]         rb_reg;
    logic [IDX_W-1:0]         col_reg;
    logic signed [DATA_W-1:0] wv_reg;
    logic signed [DATA_W-1:0] f_reg;

    logic [DIM_W-1:0] k_reg;
    logic [DIM_W-1:0] cnt_reg;
    logic             slot_reg;
    logic [2:0]       drain_reg;
    logic             resp_err_reg;

    logic             s1_valid_reg;
    logic             s1_slot_reg;
    logic [IDX_W-1:0] s1_k_reg;
    logic [DATA_W-1:0] b_data_reg;

    logic              swp_valid_reg;
    logic [ADDR_W-1:0] swp_addr_reg;
    logic [DATA_W-1:0] swp_data_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [IDX_W-1:0]  out_pos_reg;
    logic              out_last_reg;
    logic              out_err_reg;

    logic a_ok;
    logic b_ok;
    logic c_ok;
    logic out_free;
    logic strm_last;
    logic row_last;

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;
    logic [ADDR_W-1:0] strm_addr;
    logic [ADDR_W-1:0] row_addr;

    logic              dispatch_wr;
    logic              s1_row_a;
    logic              swap_wr_a;
    logic              ar_in_valid;
    logic              ar_wr_valid;
    logic [ADDR_W-1:0] ar_wr_addr;
    logic signed [DATA_W-1:0] ar_wr_data;

    assign a_ok = {1'b0, ra_reg} < nr_reg;
    assign b_ok = {1'b0, rb_reg} < nr_reg;
    assign c_ok = {1'b0, col_reg} < nc_reg;

    assign out_free  = !out_valid_reg || m_tready;
    assign strm_last = (k_reg + DIM_W'(1)) == cnt_reg;
    assign row_last  = slot_reg && ((k_reg + DIM_W'(1)) == nc_reg);

    // ---------------- memory addressing ----------------
    always_comb
    begin
        case (func_reg)
            FN_ROW:  strm_addr = cell_addr(ra_reg, k_reg[IDX_W-1:0]);
            FN_COL:  strm_addr = cell_addr(k_reg[IDX_W-1:0], col_reg);
            default: strm_addr = cell_addr(ra_reg, col_reg);
        endcase
    end

    // slot 0 fetches row B (or row A for scale), slot 1 fetches row A
    assign row_addr = (!slot_reg && func_reg != FN_SCALE) ? cell_addr(rb_reg, k_reg[IDX_W-1:0])
                                                          : cell_addr(ra_reg, k_reg[IDX_W-1:0]);

    assign mem_rd_en   = (state_reg == S_ROW_ISSUE) || (state_reg == S_RD_ISSUE);
    assign mem_rd_addr = (state_reg == S_RD_ISSUE) ? strm_addr : row_addr;

    assign dispatch_wr = (state_reg == S_DISPATCH) && (func_reg == FN_WRITE) && a_ok && c_ok;
    assign s1_row_a    = s1_valid_reg && s1_slot_reg;
    assign swap_wr_a   = s1_row_a && (func_reg == FN_SWAP);
    assign ar_in_valid = s1_row_a && (func_reg != FN_SWAP);

    // write sources never overlap in time
    always_comb
    begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ar_wr_addr;
        mem_wr_data = ar_wr_data;
        if (dispatch_wr)
        begin
            mem_wr_addr = cell_addr(ra_reg, col_reg);
            mem_wr_data = wv_reg;
        end
        else if (swap_wr_a)
        begin
            mem_wr_addr = cell_addr(ra_reg, s1_k_reg);
            mem_wr_data = b_data_reg;
        end
        else if (swp_valid_reg)
        begin
            mem_wr_addr = swp_addr_reg;
            mem_wr_data = swp_data_reg;
        end
        else
        begin
            mem_wr_en = ar_wr_valid;
        end
    end

    mre_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    mre_arith #(
        .ADDR_W (ADDR_W)
    ) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ar_in_valid),
        .in_is_sub (func_reg == FN_SUB),
        .in_a      ($signed(mem_rd_data)),
        .in_b      ($signed(b_data_reg)),
        .in_factor (f_reg),
        .in_addr   (cell_addr(ra_reg, s1_k_reg)),
        .wr_valid  (ar_wr_valid),
        .wr_addr   (ar_wr_addr),
        .wr_data   (ar_wr_data)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (func_reg)
                    FN_WRITE:
                        state_next = S_RESP;
                    FN_READ:
                        state_next = (a_ok && c_ok) ? S_RD_ISSUE : S_RESP;
                    FN_ROW:
                        state_next = a_ok ? S_RD_ISSUE : S_RESP;
                    FN_COL:
                        state_next = c_ok ? S_RD_ISSUE : S_RESP;
                    FN_SWAP:
                        state_next = (a_ok && b_ok) ? S_ROW_ISSUE : S_RESP;
                    FN_SCALE:
                        state_next = (a_ok && f_reg != '0) ? S_ROW_ISSUE : S_RESP;
                    FN_SUB:
                        state_next = (a_ok && b_ok && f_reg != '0) ? S_ROW_ISSUE : S_RESP;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_ROW_ISSUE:
            begin
                if (row_last)
                    state_next = S_ROW_DRAIN;
            end
            S_ROW_DRAIN:
            begin
                if (drain_reg == '0)
                    state_next = S_RESP;
            end
            S_RD_ISSUE:
                state_next = S_RD_DATA;
            S_RD_DATA:
            begin
                if (out_free)
                    state_next = strm_last ? S_IDLE : S_RD_ISSUE;
            end
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nr_reg        <= ROW_LIM;
            nc_reg        <= COL_LIM;
            func_reg      <= FN_WRITE;
            ra_reg        <= '0;
            rb_reg        <= '0;
            col_reg       <= '0;
            wv_reg        <= '0;
            f_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            slot_reg      <= 1'b0;
            drain_reg     <= '0;
            resp_err_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_slot_reg   <= 1'b0;
            s1_k_reg      <= '0;
            b_data_reg    <= '0;
            swp_valid_reg <= 1'b0;
            swp_addr_reg  <= '0;
            swp_data_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_pos_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                if (cfg_index == CFG_ROWS)
                    nr_reg <= clamp_dim(cfg_data, ROW_LIM);
                else if (cfg_index == CFG_COLS)
                    nc_reg <= clamp_dim(cfg_data, COL_LIM);
            end

            if (state_reg == S_IDLE && s_tvalid)
            begin
                func_reg <= func_t'(s_tuser);
                ra_reg   <= s_tdata[3:0];
                rb_reg   <= s_tdata[7:4];
                col_reg  <= s_tdata[11:8];
                wv_reg   <= $signed(s_tdata[43:12]);
                f_reg    <= $signed(s_tdata[75:44]);
            end

            // hand off the element read issued in the previous cycle
            s1_valid_reg <= (state_reg == S_ROW_ISSUE);
            s1_slot_reg  <= slot_reg;
            s1_k_reg     <= k_reg[IDX_W-1:0];
            if (s1_valid_reg && !s1_slot_reg)
                b_data_reg <= mem_rd_data;

            // second half of a swap: old row A goes to row B next cycle
            swp_valid_reg <= swap_wr_a;
            swp_addr_reg  <= cell_addr(rb_reg, s1_k_reg);
            swp_data_reg  <= mem_rd_data;

            // drop a taken result unless a new one loads this cycle
            if (out_valid_reg && m_tready && state_reg != S_RD_DATA && state_reg != S_RESP)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_DISPATCH:
                begin
                    k_reg        <= '0;
                    slot_reg     <= 1'b0;
                    case (func_reg)
                        FN_WRITE: resp_err_reg <= !(a_ok && c_ok);
                        FN_READ:
                        begin
                            resp_err_reg <= !(a_ok && c_ok);
                            cnt_reg      <= DIM_W'(1);
                        end
                        FN_ROW:
                        begin
                            resp_err_reg <= !a_ok;
                            cnt_reg      <= nc_reg;
                        end
                        FN_COL:
                        begin
                            resp_err_reg <= !c_ok;
                            cnt_reg      <= nr_reg;
                        end
                        FN_SWAP:  resp_err_reg <= !(a_ok && b_ok);
                        FN_SCALE: resp_err_reg <= !a_ok;
                        FN_SUB:   resp_err_reg <= !(a_ok && b_ok);
                        default:  resp_err_reg <= 1'b1;
                    endcase
                end
                S_ROW_ISSUE:
                begin
                    slot_reg <= !slot_reg;
                    if (slot_reg)
                        k_reg <= k_reg + DIM_W'(1);
                    drain_reg <= PIPE_DRAIN;
                end
                S_ROW_DRAIN:
                begin
                    drain_reg <= drain_reg - 3'd1;
                end
                S_RD_DATA:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= mem_rd_data;
                        out_pos_reg   <= k_reg[IDX_W-1:0];
                        out_last_reg  <= strm_last;
                        out_err_reg   <= 1'b0;
                        k_reg         <= k_reg + DIM_W'(1);
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= '0;
                        out_pos_reg   <= '0;
                        out_last_reg  <= 1'b1;
                        out_err_reg   <= resp_err_reg;
                    end
                end
                default:
                begin
                    drain_reg <= drain_reg;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - DATA_W - IDX_W){1'b0}}, out_pos_reg, out_value_reg};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_err_reg;

endmodule

`default_nettype wire

@@ design/mre_checker.sv @@
// ----------------------------------------------------------------------------
// mre_checker
// Port-level checks on the matrix row operation engine, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_checker
    import mre_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast,
    input wire logic [0:0]           m_tuser
);

    // one operation at a time: take a transaction, then stay busy
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an operation is in flight");

    // an error reply is a single, empty, final result
    a_err_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == '0))
        else $error("error reply carries data or is not last");

    // a stream in progress keeps the input closed
    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input open while a stream is unfinished");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind matrix_row_operation_engine mre_checker u_mre_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
